[sv/tmoe_pkg.sv]
package tmoe_pkg;

    localparam int OP_KIND_W   = 3;
    localparam int OP_ARG_W    = 16;
    localparam int BYTE_W      = 8;
    localparam int INDEX_W     = 16;
    localparam int COUNT_W     = 16;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    typedef enum logic [OP_KIND_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_READ  = 3'd2,
        OP_WRITE = 3'd3,
        OP_RIGHT = 3'd4,
        OP_LEFT  = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } op_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_VAL_OVER  = 3'd1,
        ST_VAL_UNDER = 3'd2,
        ST_PTR_UNDER = 3'd3,
        ST_EXHAUSTED = 3'd4,
        ST_READ_FAIL = 3'd5
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VALUE_MODE   = 1'd0,
        CFG_POINTER_MODE = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [OP_ARG_W-1:0] arg;
        logic                clear_idiom;
        logic [BYTE_W-1:0]   in_byte;
        logic                in_got;
        logic                in_fault;
    } op_item_t;

endpackage

[sv/tmoe_if.sv]
interface tmoe_op_if;
    import tmoe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_KIND_W-1:0] op_kind;
    logic [OP_ARG_W-1:0]  op_arg;
    logic                 clear_idiom;
    logic [BYTE_W-1:0]    in_byte;
    logic                 in_got;
    logic                 in_fault;

    modport source (
        output valid, op_kind, op_arg, clear_idiom, in_byte, in_got, in_fault,
        input  ready
    );
    modport sink (
        input  valid, op_kind, op_arg, clear_idiom, in_byte, in_got, in_fault,
        output ready
    );
endinterface

interface tmoe_res_if;
    import tmoe_pkg::*;

    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  fetch_index;
    logic                emit_valid;
    logic [BYTE_W-1:0]   emit_byte;
    logic [COUNT_W-1:0]  emit_count;
    logic [STATUS_W-1:0] status;
    logic                stopped;

    modport source (
        output valid, fetch_index, emit_valid, emit_byte, emit_count, status, stopped,
        input  ready
    );
    modport sink (
        input  valid, fetch_index, emit_valid, emit_byte, emit_count, status, stopped,
        output ready
    );
endinterface

[sv/tmoe_ram.sv]
module tmoe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

[sv/tape_machine_op_executor.sv]
// Pipeline: a request is registered in s1, then in execute stage x, then its result in
// the output register. Throughput: one request per cycle while results are taken;
// the tape RAM does a read-modify-write per op, with the cell written by one op
// forwarded to the next. Reset: control state clears at once, then a clearing pass
// zeroes the tape, one cell per cycle over TAPE_DEPTH cells, accepting no request.
module tape_machine_op_executor #(
    parameter int TAPE_DEPTH    = 32768,
    parameter int PROGRAM_DEPTH = 65536
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tmoe_op_if.sink                          op,
    tmoe_res_if.source                       res,
    input  logic                             cfg_we,
    input  logic [tmoe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tmoe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tmoe_pkg::*;

    localparam int HW   = $clog2(TAPE_DEPTH);
    localparam int EW   = $clog2(TAPE_DEPTH + 1);
    localparam int CW   = ((EW > OP_ARG_W) ? EW : OP_ARG_W) + 1;
    localparam int MW   = INDEX_W + 1;
    localparam int STW  = 30;

    // Pipeline control.
    logic          s1_valid_reg, s1_valid_next;
    logic          x_valid_reg, x_valid_next;
    logic          out_valid_reg, out_valid_next;
    logic          x_fire, x_load, s1_move, s1_load, accept;

    // Pipeline payload.
    op_item_t           s1_op_reg, x_op_reg, op_item;
    logic [MW-1:0]      s1_mod_reg, mod_hi, mod_lo;
    logic [INDEX_W-1:0] x_adv_reg;

    // Machine state.
    logic [HW-1:0]      head_reg, head_next;
    logic [EW-1:0]      extent_reg, extent_next;
    logic [INDEX_W-1:0] op_index_reg, op_index_next;
    logic [INDEX_W-1:0] op_next_reg, op_next_next;
    status_t            error_code_reg, error_next, err;
    logic               value_mode_reg, pointer_mode_reg;
    logic               clearing_reg;
    logic [HW-1:0]      clr_addr_reg;
    logic               fwd_hit_reg;
    logic [BYTE_W-1:0]  fwd_data_reg;

    // Execution.
    logic [BYTE_W-1:0]  ram_rdata, ram_wdata, cur_cell, cell_wdata;
    logic [HW-1:0]      ram_waddr;
    logic               ram_we, cell_we, jump;
    logic [BYTE_W:0]    add_sum;
    logic [CW-1:0]      right_sum, left_rem, left_pos;
    logic               left_under;
    logic [MW-1:0]      seq_inc;
    logic [INDEX_W-1:0] seq_adv;
    logic               emit_v;
    logic [BYTE_W-1:0]  emit_b;
    logic [COUNT_W-1:0] emit_c;

    // Output register.
    logic [INDEX_W-1:0]  out_fetch_reg;
    logic                out_emit_valid_reg;
    logic [BYTE_W-1:0]   out_emit_byte_reg;
    logic [COUNT_W-1:0]  out_emit_count_reg;
    status_t             out_status_reg;

    assign x_fire  = x_valid_reg && (!out_valid_reg || res.ready);
    assign x_load  = !x_valid_reg || x_fire;
    assign s1_move = s1_valid_reg && x_load;
    assign s1_load = !s1_valid_reg || s1_move;
    assign op.ready = !clearing_reg && s1_load;
    assign accept  = op.valid && op.ready;

    assign s1_valid_next  = accept || (s1_valid_reg && !s1_move);
    assign x_valid_next   = s1_move || (x_valid_reg && !x_fire);
    assign out_valid_next = x_fire || (out_valid_reg && !res.ready);

    assign op_item.kind        = op_kind_t'(op.op_kind);
    assign op_item.arg         = op.op_arg;
    assign op_item.clear_idiom = op.clear_idiom;
    assign op_item.in_byte     = op.in_byte;
    assign op_item.in_got      = op.in_got;
    assign op_item.in_fault    = op.in_fault;

    // The jump target's successor, (arg + 1) mod PROGRAM_DEPTH, is reduced by
    // restoring subtraction of shifted copies of the depth, split over two stages.
    always_comb
    begin : mod_hi_calc
        logic [STW-1:0] step;
        logic [MW-1:0]  acc;
        acc = MW'(op.op_arg) + MW'(1);
        for (int k = 8; k >= 4; k--)
        begin
            step = STW'(PROGRAM_DEPTH) << k;
            if (STW'(acc) >= step)
            begin
                acc = acc - step[MW-1:0];
            end
        end
        mod_hi = acc;
    end

    always_comb
    begin : mod_lo_calc
        logic [STW-1:0] step;
        logic [MW-1:0]  acc;
        acc = s1_mod_reg;
        for (int k = 3; k >= 0; k--)
        begin
            step = STW'(PROGRAM_DEPTH) << k;
            if (STW'(acc) >= step)
            begin
                acc = acc - step[MW-1:0];
            end
        end
        mod_lo = acc;
    end

    // Sequential successor of a value already below the program depth.
    assign seq_inc = MW'(op_next_reg) + MW'(1);
    assign seq_adv = (STW'(seq_inc) == STW'(PROGRAM_DEPTH)) ? '0 : seq_inc[INDEX_W-1:0];

    assign cur_cell   = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    // The low byte of the count is added here; in value mode any higher bit alone means overflow.
    assign add_sum    = (BYTE_W + 1)'(cur_cell) + (BYTE_W + 1)'(x_op_reg.arg[BYTE_W-1:0]);
    assign right_sum  = CW'(head_reg) + CW'(x_op_reg.arg);
    assign left_under = CW'(head_reg) < CW'(x_op_reg.arg);
    assign left_rem   = CW'(x_op_reg.arg) - CW'(head_reg);
    assign left_pos   = CW'(extent_reg) - left_rem;

    always_comb
    begin
        head_next     = head_reg;
        extent_next   = extent_reg;
        op_index_next = op_index_reg;
        op_next_next  = op_next_reg;
        error_next    = error_code_reg;
        err           = ST_OK;
        jump          = 1'b0;
        cell_we       = 1'b0;
        cell_wdata    = cur_cell;
        emit_v        = 1'b0;
        emit_b        = '0;
        emit_c        = '0;
        if (x_fire && error_code_reg == ST_OK)
        begin
            case (x_op_reg.kind)
                OP_ADD:
                begin
                    if (value_mode_reg && (add_sum[BYTE_W]
                        || x_op_reg.arg[OP_ARG_W-1:BYTE_W] != '0))
                    begin
                        err = ST_VAL_OVER;
                    end
                    else
                    begin
                        cell_we    = 1'b1;
                        cell_wdata = add_sum[BYTE_W-1:0];
                    end
                end
                OP_SUB:
                begin
                    if (value_mode_reg && OP_ARG_W'(cur_cell) < x_op_reg.arg)
                    begin
                        err = ST_VAL_UNDER;
                    end
                    else
                    begin
                        cell_we    = 1'b1;
                        cell_wdata = cur_cell - x_op_reg.arg[BYTE_W-1:0];
                    end
                end
                OP_READ:
                begin
                    if (x_op_reg.arg != '0)
                    begin
                        if (x_op_reg.in_got)
                        begin
                            cell_we    = 1'b1;
                            cell_wdata = x_op_reg.in_byte;
                        end
                        if (x_op_reg.in_fault)
                        begin
                            err = ST_READ_FAIL;
                        end
                    end
                end
                OP_WRITE:
                begin
                    if (x_op_reg.arg != '0)
                    begin
                        emit_v = 1'b1;
                        emit_b = cur_cell;
                        emit_c = x_op_reg.arg;
                    end
                end
                OP_RIGHT:
                begin
                    if (right_sum >= CW'(TAPE_DEPTH))
                    begin
                        err = ST_EXHAUSTED;
                    end
                    else
                    begin
                        head_next = right_sum[HW-1:0];
                        if (right_sum >= CW'(extent_reg))
                        begin
                            extent_next = EW'(right_sum + CW'(1));
                        end
                    end
                end
                OP_LEFT:
                begin
                    if (left_under)
                    begin
                        if (pointer_mode_reg || left_rem > CW'(extent_reg))
                        begin
                            err = ST_PTR_UNDER;
                        end
                        else
                        begin
                            head_next = left_pos[HW-1:0];
                        end
                    end
                    else
                    begin
                        head_next = head_reg - x_op_reg.arg[HW-1:0];
                    end
                end
                OP_OPEN:
                begin
                    if (cur_cell != '0)
                    begin
                        if (x_op_reg.clear_idiom)
                        begin
                            if (value_mode_reg)
                            begin
                                err = ST_VAL_OVER;
                            end
                            else
                            begin
                                cell_we    = 1'b1;
                                cell_wdata = '0;
                                jump       = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        jump = 1'b1;
                    end
                end
                OP_CLOSE:
                begin
                    jump = (cur_cell != '0);
                end
                default:
                begin
                    jump = 1'b0;
                end
            endcase

            if (err != ST_OK)
            begin
                error_next = err;
                emit_v     = 1'b0;
                emit_b     = '0;
                emit_c     = '0;
            end
            else if (jump)
            begin
                op_index_next = x_op_reg.arg;
                op_next_next  = x_adv_reg;
            end
            else
            begin
                op_index_next = op_next_reg;
                op_next_next  = seq_adv;
            end
        end
    end

    assign ram_we    = clearing_reg || cell_we;
    assign ram_waddr = clearing_reg ? clr_addr_reg : head_reg;
    assign ram_wdata = clearing_reg ? '0 : cell_wdata;

    // The read for the next op is issued at the head as it stands after the current op.
    tmoe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            x_valid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            head_reg         <= '0;
            extent_reg       <= EW'(1);
            op_index_reg     <= '0;
            op_next_reg      <= INDEX_W'(1);
            error_code_reg   <= ST_OK;
            value_mode_reg   <= 1'b0;
            pointer_mode_reg <= 1'b0;
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            fwd_hit_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            x_valid_reg    <= x_valid_next;
            out_valid_reg  <= out_valid_next;
            head_reg       <= head_next;
            extent_reg     <= extent_next;
            op_index_reg   <= op_index_next;
            op_next_reg    <= op_next_next;
            error_code_reg <= error_next;
            fwd_hit_reg    <= cell_we;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + HW'(1);
                if (clr_addr_reg == HW'(TAPE_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_VALUE_MODE:   value_mode_reg   <= cfg_data[0];
                    CFG_POINTER_MODE: pointer_mode_reg <= cfg_data[0];
                    default:          value_mode_reg   <= value_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= cell_wdata;
        if (accept)
        begin
            s1_op_reg  <= op_item;
            s1_mod_reg <= mod_hi;
        end
        if (s1_move)
        begin
            x_op_reg  <= s1_op_reg;
            x_adv_reg <= mod_lo[INDEX_W-1:0];
        end
        if (x_fire)
        begin
            out_fetch_reg      <= op_index_next;
            out_emit_valid_reg <= emit_v;
            out_emit_byte_reg  <= emit_b;
            out_emit_count_reg <= emit_c;
            out_status_reg     <= error_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.fetch_index = out_fetch_reg;
    assign res.emit_valid  = out_emit_valid_reg;
    assign res.emit_byte   = out_emit_byte_reg;
    assign res.emit_count  = out_emit_count_reg;
    assign res.status      = out_status_reg;
    assign res.stopped     = (out_status_reg != ST_OK);

    a_extent_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> extent_reg >= $past(extent_reg))
        else $error("tape extent shrank");

    a_head_in_extent: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(head_reg) < extent_reg)
        else $error("head beyond tape extent");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_code_reg != ST_OK |=> error_code_reg == $past(error_code_reg)
            && op_index_reg == $past(op_index_reg) && head_reg == $past(head_reg))
        else $error("machine state changed after a stop");

    a_no_write_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        error_code_reg != ST_OK |-> !cell_we)
        else $error("tape written after a stop");

endmodule

[tb/tape_machine_op_executor_test.sv]
`timescale 1ns / 1ps

module tape_machine_op_executor_test;
    import tmoe_pkg::*;

    localparam int TAPE_CELLS    = 32768;
    localparam int PROGRAM_SLOTS = 65536;
    // The clearing pass after reset moves no request or result, so it counts as quiet.
    localparam int QUIET_LIMIT   = 100000;

    typedef struct packed {
        logic [INDEX_W-1:0] fetch_index;
        logic               emit_valid;
        logic [BYTE_W-1:0]  emit_byte;
        logic [COUNT_W-1:0] emit_count;
        status_t            status;
        logic               stopped;
    } op_outcome_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tmoe_op_if  op_ch ();
    tmoe_res_if res_ch ();

    tape_machine_op_executor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow machine state.
    logic [7:0] tape_mem [TAPE_CELLS];
    int         head;
    int         extent;
    int         op_idx;
    status_t    stop_code;
    bit         val_stop;
    bit         ptr_stop;

    op_outcome_t outcome_q [$];
    int          mismatches;
    int          results_seen;
    int          emits_seen;
    int          kind_count [8];
    bit          send_gaps;
    bit          take_gaps;
    int          hold_request;
    string       halt_reason;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 60)
            $display("[%0t] MISMATCH on result %0d: %s", $realtime, results_seen, msg);
    endtask

    function automatic op_item_t make_op(op_kind_t k, int arg, bit clr = 1'b0,
                                         int b = 0, bit got = 1'b0, bit flt = 1'b0);
        op_item_t it;
        it.kind        = k;
        it.arg         = 16'(arg);
        it.clear_idiom = clr;
        it.in_byte     = 8'(b);
        it.in_got      = got;
        it.in_fault    = flt;
        return it;
    endfunction

    // Executes one op on the shadow state; with commit low the state is left alone,
    // so the same code tells whether a candidate request would halt the machine.
    function automatic op_outcome_t run_op(op_item_t it, bit commit);
        op_outcome_t r;
        status_t     fault_code;
        int          h;
        int          cur;
        int          arg;
        int          nxt;
        int          rem;
        int          head_nxt;
        int          extent_nxt;
        bit          cur_wr;
        logic [7:0]  cur_val;

        r          = '0;
        h          = head % TAPE_CELLS;
        cur        = int'(tape_mem[h]);
        arg        = int'(it.arg);
        nxt        = (op_idx + 1) % PROGRAM_SLOTS;
        fault_code = ST_OK;
        head_nxt   = head;
        extent_nxt = extent;
        cur_wr     = 1'b0;
        cur_val    = '0;

        if (stop_code != ST_OK)
        begin
            r.fetch_index = INDEX_W'(op_idx);
            r.status      = stop_code;
            r.stopped     = 1'b1;
            return r;
        end

        case (it.kind)
            OP_ADD:
                if (val_stop && cur + arg > 255)
                    fault_code = ST_VAL_OVER;
                else
                begin
                    cur_wr  = 1'b1;
                    cur_val = 8'(cur + arg);
                end
            OP_SUB:
                if (val_stop && cur < arg)
                    fault_code = ST_VAL_UNDER;
                else
                begin
                    cur_wr  = 1'b1;
                    cur_val = 8'(cur - arg);
                end
            OP_READ:
                if (arg != 0)
                begin
                    if (it.in_got)
                    begin
                        cur_wr  = 1'b1;
                        cur_val = it.in_byte;
                    end
                    if (it.in_fault)
                        fault_code = ST_READ_FAIL;
                end
            OP_WRITE:
                if (arg != 0)
                begin
                    r.emit_valid = 1'b1;
                    r.emit_byte  = 8'(cur);
                    r.emit_count = COUNT_W'(arg);
                end
            OP_RIGHT:
                if (h + arg >= TAPE_CELLS)
                    fault_code = ST_EXHAUSTED;
                else
                begin
                    head_nxt = h + arg;
                    if (head_nxt >= extent)
                        extent_nxt = head_nxt + 1;
                end
            OP_LEFT:
                if (h < arg)
                begin
                    // Below cell zero the head wraps back from the end of the used tape.
                    rem = arg - h;
                    if (ptr_stop || rem > extent)
                        fault_code = ST_PTR_UNDER;
                    else
                        head_nxt = extent - rem;
                end
                else
                    head_nxt = h - arg;
            OP_OPEN:
                if (cur != 0)
                begin
                    if (it.clear_idiom)
                    begin
                        if (val_stop)
                            fault_code = ST_VAL_OVER;
                        else
                        begin
                            cur_wr  = 1'b1;
                            cur_val = '0;
                            nxt     = arg;
                        end
                    end
                end
                else
                    nxt = arg;
            default:
                if (cur != 0)
                    nxt = arg;
        endcase

        if (fault_code != ST_OK)
        begin
            r             = '0;
            r.fetch_index = INDEX_W'(op_idx);
            r.status      = fault_code;
            r.stopped     = 1'b1;
            if (commit)
                stop_code = fault_code;
        end
        else
        begin
            r.fetch_index = INDEX_W'(nxt);
            r.status      = ST_OK;
            r.stopped     = 1'b0;
            if (commit)
            begin
                if (cur_wr)
                    tape_mem[h] = cur_val;
                head   = head_nxt;
                extent = extent_nxt;
                op_idx = nxt;
            end
        end
        return r;
    endfunction

    // Random request shaped by the current head and extent so that moves reach
    // both ends of the tape.
    function automatic op_item_t draw_op();
        op_item_t it;
        int       sel;

        it             = '0;
        it.kind        = op_kind_t'($urandom_range(0, 7));
        it.clear_idiom = 1'($urandom_range(0, 1));
        it.in_byte     = 8'($urandom_range(0, 255));
        it.in_got      = 1'($urandom_range(0, 1));
        it.in_fault    = ($urandom_range(0, 3) == 0);
        sel            = $urandom_range(0, 7);
        case (it.kind)
            OP_ADD, OP_SUB:
                it.arg = (sel == 0) ? 16'($urandom_range(0, 65535))
                                    : 16'($urandom_range(0, 260));
            OP_READ, OP_WRITE:
                it.arg = (sel == 0) ? 16'($urandom_range(0, 65535))
                                    : 16'($urandom_range(0, 3));
            OP_RIGHT:
                if (sel == 0)
                    it.arg = 16'($urandom_range(0, 65535));
                else if (sel < 3)
                    it.arg = 16'($urandom_range(0, TAPE_CELLS - 1 - head));
                else
                    it.arg = 16'($urandom_range(0, 40));
            OP_LEFT:
                if (sel == 0)
                    it.arg = 16'($urandom_range(0, 65535));
                else if (sel < 3)
                    it.arg = 16'($urandom_range(0, head + extent));
                else
                    it.arg = 16'($urandom_range(0, 40));
            default:
                it.arg = 16'($urandom_range(0, 65535));
        endcase
        return it;
    endfunction

    task automatic send_op(op_item_t it);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            op_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clk);
        end
        @(negedge clk);
        op_ch.valid       = 1'b1;
        op_ch.op_kind     = it.kind;
        op_ch.op_arg      = it.arg;
        op_ch.clear_idiom = it.clear_idiom;
        op_ch.in_byte     = it.in_byte;
        op_ch.in_got      = it.in_got;
        op_ch.in_fault    = it.in_fault;
        do
            @(posedge clk);
        while (op_ch.ready !== 1'b1);
        outcome_q.push_back(run_op(it, 1'b1));
        kind_count[it.kind]++;
    endtask

    task automatic drain();
        @(negedge clk);
        op_ch.valid = 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode_reg(cfg_reg_t idx, bit val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_VALUE_MODE)
            val_stop = val;
        else
            ptr_stop = val;
    endtask

    task automatic set_modes(bit v, bit p);
        drain();
        write_mode_reg(CFG_VALUE_MODE, v);
        write_mode_reg(CFG_POINTER_MODE, p);
    endtask

    task automatic apply_reset();
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        // The tape is cleared before the first request is taken.
        do
            @(posedge clk);
        while (op_ch.ready !== 1'b1);
    endtask

    task automatic test_directed_wrap();
        set_modes(1'b0, 1'b0);
        send_op(make_op(OP_ADD, 255));
        send_op(make_op(OP_ADD, 1));
        send_op(make_op(OP_SUB, 1));
        send_op(make_op(OP_ADD, 16'hFFFF));
        send_op(make_op(OP_WRITE, 0));
        send_op(make_op(OP_WRITE, 16'hFFFF));
        send_op(make_op(OP_READ, 0, 1'b0, 8'h5A, 1'b1, 1'b1));
        send_op(make_op(OP_READ, 1, 1'b0, 8'hA5, 1'b1, 1'b0));
        send_op(make_op(OP_READ, 3, 1'b0, 8'h5A, 1'b0, 1'b0));
        send_op(make_op(OP_OPEN, 16'h1234, 1'b1));
        send_op(make_op(OP_OPEN, 16'hFFFF));
        // The index sits at the top of the program, so the advance wraps to zero.
        send_op(make_op(OP_CLOSE, 16'h0ABC));
        send_op(make_op(OP_ADD, 7));
        send_op(make_op(OP_OPEN, 16'h00FF));
        send_op(make_op(OP_CLOSE, 16'h8000));
        send_op(make_op(OP_RIGHT, TAPE_CELLS - 1));
        send_op(make_op(OP_WRITE, 1));
        send_op(make_op(OP_LEFT, TAPE_CELLS - 1));
        send_op(make_op(OP_LEFT, TAPE_CELLS));
        send_op(make_op(OP_LEFT, 0));
        send_op(make_op(OP_LEFT, 1));
        send_op(make_op(OP_SUB, 16'h0101));
    endtask

    task automatic test_directed_stop_modes();
        set_modes(1'b1, 1'b1);
        send_op(make_op(OP_LEFT, head));
        send_op(make_op(OP_ADD, 255 - tape_mem[head]));
        send_op(make_op(OP_SUB, 255));
        send_op(make_op(OP_OPEN, 16'h4321, 1'b1));
    endtask

    task automatic test_random_phases();
        bit [1:0]    settings [5];
        op_item_t    it;
        op_outcome_t probe;
        int          tries;

        settings = '{2'b00, 2'b11, 2'b10, 2'b01, 2'b11};
        for (int p = 0; p < 5; p++)
        begin
            set_modes(settings[p][1], settings[p][0]);
            if (p == 4)
            begin
                send_gaps = 1'b0;
                take_gaps = 1'b0;
            end
            for (int n = 0; n < 240; n++)
            begin
                if (p < 4 && n % 60 == 0)
                begin
                    send_gaps = ($urandom_range(0, 3) != 0);
                    take_gaps = ($urandom_range(0, 3) != 0);
                end
                if (p == 1 && n == 0)
                begin
                    // Results are held back while requests keep coming, so the
                    // block fills and stalls its input.
                    send_gaps    = 1'b0;
                    hold_request = 300;
                end
                // A halt is sticky, so requests that would stop the machine are redrawn.
                tries = 0;
                do
                begin
                    it    = draw_op();
                    probe = run_op(it, 1'b0);
                    tries++;
                end
                while (probe.status != ST_OK && tries < 20);
                if (probe.status != ST_OK)
                    it = make_op(OP_WRITE, 0);
                send_op(it);
            end
        end
    endtask

    task automatic test_sticky_stop();
        int       cause;
        int       cur;
        int       lo;
        op_item_t it;

        cause = $urandom_range(0, 6);
        if (cause == 4 && head + extent + 1 > 65535)
            cause = 3;
        cur = int'(tape_mem[head]);
        case (cause)
            0:
            begin
                set_modes(1'b1, 1'b0);
                it = make_op(OP_ADD, 256 - cur + $urandom_range(0, 200));
            end
            1:
            begin
                if (cur == 0)
                begin
                    set_modes(1'b0, 1'b0);
                    send_op(make_op(OP_ADD, $urandom_range(1, 255)));
                end
                set_modes(1'b1, 1'b0);
                it = make_op(OP_OPEN, $urandom_range(0, 65535), 1'b1);
            end
            2:
            begin
                set_modes(1'b1, 1'b0);
                it = make_op(OP_SUB, cur + 1 + $urandom_range(0, 200));
            end
            3:
            begin
                set_modes(1'b0, 1'b1);
                it = make_op(OP_LEFT, head + 1 + $urandom_range(0, 200));
            end
            4:
            begin
                set_modes(1'b0, 1'b0);
                lo = head + extent + 1;
                it = make_op(OP_LEFT, lo + $urandom_range(0, 65535 - lo));
            end
            5:
            begin
                set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                it = make_op(OP_RIGHT, TAPE_CELLS - head + $urandom_range(0, 200));
            end
            default:
            begin
                set_modes(1'b0, 1'b0);
                it = make_op(OP_READ, $urandom_range(1, 65535), 1'b0,
                             $urandom_range(0, 255), 1'($urandom_range(0, 1)), 1'b1);
            end
        endcase
        send_op(it);
        halt_reason = stop_code.name();
        // Everything after the halt must be ignored.
        repeat (25)
            send_op(draw_op());
    endtask

    initial
    begin : result_taker
        int stall_left;
        int hold_left;

        stall_left   = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready = 1'b0;
                stall_left--;
            end
            else if (take_gaps && $urandom_range(0, 9) == 0)
            begin
                res_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 15) - 1;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        op_outcome_t want;

        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            results_seen++;
            if (res_ch.emit_valid === 1'b1)
                emits_seen++;
            if (outcome_q.size() == 0)
                log_mismatch("result arrived with no request pending");
            else
            begin
                want = outcome_q.pop_front();
                if (res_ch.fetch_index !== want.fetch_index)
                    log_mismatch($sformatf("fetch_index %0d, expected %0d",
                                           res_ch.fetch_index, want.fetch_index));
                if (res_ch.emit_valid !== want.emit_valid)
                    log_mismatch($sformatf("emit_valid %0b, expected %0b",
                                           res_ch.emit_valid, want.emit_valid));
                if (res_ch.emit_byte !== want.emit_byte)
                    log_mismatch($sformatf("emit_byte 0x%02h, expected 0x%02h",
                                           res_ch.emit_byte, want.emit_byte));
                if (res_ch.emit_count !== want.emit_count)
                    log_mismatch($sformatf("emit_count %0d, expected %0d",
                                           res_ch.emit_count, want.emit_count));
                if (res_ch.status !== want.status)
                    log_mismatch($sformatf("status %0d, expected %0d",
                                           res_ch.status, want.status));
                if (res_ch.stopped !== want.stopped)
                    log_mismatch($sformatf("stopped %0b, expected %0b",
                                           res_ch.stopped, want.stopped));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((op_ch.valid === 1'b1 && op_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_VALUE_MODE;
        cfg_data          = '0;
        op_ch.valid       = 1'b0;
        op_ch.op_kind     = OP_ADD;
        op_ch.op_arg      = '0;
        op_ch.clear_idiom = 1'b0;
        op_ch.in_byte     = '0;
        op_ch.in_got      = 1'b0;
        op_ch.in_fault    = 1'b0;
        foreach (tape_mem[i])
            tape_mem[i] = '0;
        head         = 0;
        extent       = 1;
        op_idx       = 0;
        stop_code    = ST_OK;
        val_stop     = 1'b0;
        ptr_stop     = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        emits_seen   = 0;
        hold_request = 0;
        send_gaps    = 1'b1;
        take_gaps    = 1'b1;
        halt_reason  = "none";
        foreach (kind_count[i])
            kind_count[i] = 0;

        apply_reset();
        test_directed_wrap();
        test_directed_stop_modes();
        test_random_phases();
        test_sticky_stop();
        drain();
        repeat (10) @(posedge clk);
        if (outcome_q.size() != 0)
            log_mismatch($sformatf("%0d expected results never arrived", outcome_q.size()));

        $display("Covered %0d results (%0d with bytes emitted) from ops add %0d, sub %0d,",
                 results_seen, emits_seen, kind_count[OP_ADD], kind_count[OP_SUB]);
        $display("read %0d, write %0d, right %0d, left %0d, open %0d, close %0d; halted by %s",
                 kind_count[OP_READ], kind_count[OP_WRITE], kind_count[OP_RIGHT],
                 kind_count[OP_LEFT], kind_count[OP_OPEN], kind_count[OP_CLOSE], halt_reason);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
sv/tmoe_pkg.sv
sv/tmoe_if.sv
sv/tmoe_ram.sv
sv/tape_machine_op_executor.sv
tb/tape_machine_op_executor_test.sv
